FILE: rtl/core/lss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lss_pkg;

  localparam int DEPTH = 128;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_TOP    = 2'd2,
    OP_SEARCH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    op_t                operation;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic signed [7:0]  position;
    status_t            status;
    logic               is_empty;
    logic [7:0]         count;
  } result_t;

  localparam logic signed [31:0] DATA_NONE = 32'sd0;
  localparam logic signed [31:0] DATA_EMPTY = -32'sd1;
  localparam logic signed [7:0]  POS_NONE = -8'sd1;

  function automatic logic [7:0] cnt_to8(input logic [CNT_W-1:0] c);
    logic [CNT_W+7:0] w;
    w = {8'b0, c};
    return w[7:0];
  endfunction

  function automatic logic [7:0] idx_to8(input logic [IDX_W-1:0] i);
    logic [IDX_W+7:0] w;
    w = {8'b0, i};
    return w[7:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lifo_stack_with_search_top.sv
`timescale 1ns / 1ps
`default_nettype none

// LIFO stack of signed 32-bit words with push, pop, top and search.
// Command channel: cmd is taken at a rising edge with start high and busy low.
// Result channel: result is valid for exactly one cycle while done is high;
// the receiver cannot stall, so each result must be taken in that cycle.
// Steps from accept to done:
//   push, or pop/top/search on an empty stack: done is registered directly
//   pop and top: via S_READ (one registered read of the word array)
//   search: via S_SCAN, k = entries compared from the top (1 to count);
//     one comparator walks the array one entry a cycle
// busy is high while a pop, top or search is in progress; a new command may
// be issued in the cycle that done is high.
// Reset (rst, synchronous) empties the stack and clears done; word contents
// are not cleared and need no clearing pass.

module lifo_stack_with_search_top (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire lss_pkg::cmd_t   cmd,
  output logic                 busy,
  output logic                 done,
  output lss_pkg::result_t     result
);
  import lss_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  state_t             state, state_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [IDX_W-1:0]   ptr, ptr_next;
  op_t                op;
  logic signed [31:0] key;
  logic               done_next;
  result_t            res_next;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   top_idx;
  logic [CNT_W-1:0]   cnt_m1;
  logic               wr_en;
  logic               accept;

  assign accept  = start && !busy;
  assign busy    = (state != S_IDLE);
  assign cnt_m1  = CNT_W'(cnt - CNT_W'(1));
  assign top_idx = cnt_m1[IDX_W-1:0];
  assign rd_addr = (state == S_SCAN) ? IDX_W'(ptr - IDX_W'(1)) : top_idx;
  assign wr_en   = accept && (cmd.operation == OP_PUSH) && (cnt != DEPTH_CNT);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt[IDX_W-1:0]] <= cmd.value;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    ptr_next        = ptr;
    done_next       = 1'b0;
    res_next.data   = DATA_NONE;
    res_next.position = POS_NONE;
    res_next.status = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd.operation)
            OP_PUSH: begin
              done_next = 1'b1;
              if (cnt == DEPTH_CNT) begin
                res_next.status = ST_OVERFLOW;
              end else begin
                cnt_next = CNT_W'(cnt + CNT_W'(1));
              end
            end
            OP_POP, OP_TOP: begin
              if (cnt == '0) begin
                done_next       = 1'b1;
                res_next.data   = DATA_EMPTY;
                res_next.status = ST_EMPTY;
              end else begin
                state_next = S_READ;
              end
            end
            OP_SEARCH: begin
              if (cnt == '0) begin
                done_next       = 1'b1;
                res_next.status = ST_NOT_FOUND;
              end else begin
                ptr_next   = top_idx;
                state_next = S_SCAN;
              end
            end
            default: begin
              done_next = 1'b0;
            end
          endcase
        end
      end
      S_READ: begin
        done_next     = 1'b1;
        res_next.data = rd_data;
        if (op == OP_POP) begin
          cnt_next = cnt_m1;
        end
        state_next = S_IDLE;
      end
      S_SCAN: begin
        if (rd_data == key) begin
          done_next         = 1'b1;
          res_next.position = idx_to8(ptr);
          state_next        = S_IDLE;
        end else if (ptr == '0) begin
          done_next       = 1'b1;
          res_next.status = ST_NOT_FOUND;
          state_next      = S_IDLE;
        end else begin
          ptr_next = IDX_W'(ptr - IDX_W'(1));
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    res_next.is_empty = (cnt_next == '0);
    res_next.count    = cnt_to8(cnt_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr    <= ptr_next;
    result <= res_next;
    if (accept) begin
      op  <= cmd.operation;
      key <= cmd.value;
    end
  end

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (done || busy))
    else $error("accepted command neither finished nor in progress");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while sequencer busy");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.is_empty == (cnt == '0)))
    else $error("empty flag disagrees with fill count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= DEPTH_CNT)
    else $error("fill count beyond depth");

endmodule

`default_nettype wire
